>>> src/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: shared types, constants and helpers of the calendar date stepper
// Field widths, command and sequencer codes, and the month length rule.
// ----------------------------------------------------------------------------
package cds_pkg;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 16;

  // default width of the signed amount field
  localparam int AMOUNT_BITS_DEF = 16;

  // reset date
  localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);
  localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(1970);

  // calendar constants
  localparam logic [MONTH_W-1:0] MON_JAN  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MON_FEB  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MON_MAR  = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MON_JUL  = MONTH_W'(7);
  localparam logic [MONTH_W-1:0] MONTHS   = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAYS_FEB      = DAY_W'(28);
  localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = DAY_W'(29);
  localparam logic [DAY_W-1:0]   DAYS_SHORT    = DAY_W'(30);
  localparam logic [DAY_W-1:0]   DAYS_LONG     = DAY_W'(31);

  // divisibility by 25: a * inverse(25) mod 2^16 falls at or below 65535/25
  localparam logic [YEAR_W-1:0] INV25     = 16'h5C29;
  localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(65535 / 25);

  // command codes
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_DAYS   = 2'd1,
    FN_MONTHS = 2'd2,
    FN_YEARS  = 2'd3
  } func_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD1,
    ST_LD2,
    ST_DIV,
    ST_MEND,
    ST_YFIX,
    ST_DAYF,
    ST_DAYB,
    ST_LEAP1,
    ST_LEAP2,
    ST_FIN
  } cds_state_t;

  // days in a month given the leap flag of its year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] d;
    if (m == MON_FEB) begin
      d = leap ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (m <= MON_JUL) begin
      d = m[0] ? DAYS_LONG : DAYS_SHORT;
    end else begin
      d = m[0] ? DAYS_SHORT : DAYS_LONG;
    end
    return d;
  endfunction

endpackage

>>> src/cds_if.sv
// ----------------------------------------------------------------------------
// cds_if: command and result channels of the calendar date stepper
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cds_cmd_if #(
  parameter int AMOUNT_BITS = cds_pkg::AMOUNT_BITS_DEF
);
  import cds_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [AMOUNT_BITS-1:0] amount;
  logic [DAY_W-1:0]          load_day;
  logic [MONTH_W-1:0]        load_month;
  logic signed [YEAR_W-1:0]  load_year;

  modport source (output valid, func, amount, load_day, load_month, load_year,
                  input ready);
  modport sink   (input valid, func, amount, load_day, load_month, load_year,
                  output ready);
endinterface

interface cds_res_if;
  import cds_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DAY_W-1:0]         cur_day;
  logic [MONTH_W-1:0]       cur_month;
  logic signed [YEAR_W-1:0] cur_year;
  logic                     date_valid;
  logic                     load_error;
  logic [DAY_W-1:0]         month_days;
  logic                     leap_year;

  modport source (output valid, cur_day, cur_month, cur_year, date_valid,
                  load_error, month_days, leap_year,
                  input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, date_valid,
                  load_error, month_days, leap_year,
                  output ready);
endinterface

>>> src/cds_leap.sv
// ----------------------------------------------------------------------------
// cds_leap: leap year unit
// One multiply stage, then the 4 / 100 / 400 rule on the magnitude of the
// year. The flag is valid in the cycle after the year is presented.
// ----------------------------------------------------------------------------
module cds_leap (
  input  logic                              clk,
  input  logic signed [cds_pkg::YEAR_W-1:0] year,
  output logic                              leap
);
  import cds_pkg::*;

  logic [YEAR_W-1:0] mag;
  logic [YEAR_W-1:0] prod_q;
  logic [3:0]        low_q;
  logic              div4;
  logic              div16;
  logic              div25;

  // magnitude of the year; the most negative year maps onto 32768
  assign mag = year[YEAR_W-1] ? (~year + 1'b1) : year;

  // low half of mag * inverse(25), registered with the low bits of mag
  always_ff @(posedge clk) begin
    prod_q <= YEAR_W'(mag * INV25);
    low_q  <= mag[3:0];
  end

  // divisible by 400 means divisible by 16 and by 25
  assign div4  = (low_q[1:0] == 2'd0);
  assign div16 = (low_q == 4'd0);
  assign div25 = (prod_q <= DIV25_MAX);
  assign leap  = div4 && (!div25 || div16);

endmodule

>>> src/calendar_date_stepper.sv
// Sequence, accept to result: a load runs LD1, LD2 and FIN; add years runs LEAP1,
// LEAP2, YFIX and FIN; add months runs DIV, MEND, LEAP1, LEAP2 and FIN (divide by
// 12 as a shift plus a reciprocal multiply). Add days steps a month at a time in
// DAYF or DAYB and reruns the leap unit on each new year; a zero amount goes
// straight to FIN. One word in flight; the next is taken when the sequencer is
// back in idle. Synchronous reset: 1-1-1970.
// ----------------------------------------------------------------------------
// calendar_date_stepper: Gregorian date register with load and add commands
// Holds day, month and year; loads a checked date or moves it by days,
// months or years under a small sequencer around a shared leap unit.
// ----------------------------------------------------------------------------
module calendar_date_stepper #(
  parameter int AMOUNT_BITS = cds_pkg::AMOUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cds_cmd_if.sink    cmd,
  cds_res_if.source  res
);
  import cds_pkg::*;

  localparam int MW    = AMOUNT_BITS + 1;
  localparam int SW    = (MW > YEAR_W) ? MW : YEAR_W;
  localparam int CW    = (AMOUNT_BITS > DAY_W) ? AMOUNT_BITS : DAY_W;
  // x / 12 = (x >> 2) / 3; the divide by 3 is a multiply by (2^RK + 1) / 3
  localparam int YW    = MW - 2;
  localparam int RK    = (YW % 2 == 1) ? YW : YW + 1;
  localparam int PW    = YW + RK;
  localparam logic [RK-1:0] RECIP3 = RK'(((64'd1 << RK) + 64'd1) / 64'd3);

  cds_state_t state, state_next;
  cds_state_t ret_state, ret_state_next;

  logic [DAY_W-1:0]   day_reg, day_next;
  logic [MONTH_W-1:0] month_reg, month_next;
  logic [YEAR_W-1:0]  year_reg, year_next;
  logic               leap_reg, leap_next;
  logic               err_reg, err_next;

  logic [DAY_W-1:0]   ld_day, ld_day_next;
  logic [MONTH_W-1:0] ld_month, ld_month_next;
  logic [YEAR_W-1:0]  ld_year, ld_year_next;

  logic [AMOUNT_BITS-1:0] day_rem, day_rem_next;
  logic [MW-1:0]          div_q, div_q_next;
  logic [MONTH_W-1:0]     div_rem, div_rem_next;
  logic                   div_neg, div_neg_next;

  logic               out_valid, out_valid_next;
  logic [DAY_W-1:0]   out_day, out_day_next;
  logic [MONTH_W-1:0] out_month, out_month_next;
  logic [YEAR_W-1:0]  out_year, out_year_next;
  logic               out_dvalid, out_dvalid_next;
  logic               out_err, out_err_next;
  logic [DAY_W-1:0]   out_mdays, out_mdays_next;
  logic               out_leap, out_leap_next;

  // shared leap unit and its operand
  logic signed [YEAR_W-1:0] leap_op;
  logic                     leap_q;

  // command decode
  logic [AMOUNT_BITS-1:0]   amt_u;
  logic signed [SW-1:0]     amt_ext;
  logic signed [MW-1:0]     m0;

  // datapath helpers
  logic [DAY_W-1:0]         cur_md;
  logic [DAY_W-1:0]         gap;
  logic                     ld_ok;
  logic [YW-1:0]            div_y;
  logic [PW-1:0]            div_prod;
  logic [YW-1:0]            div_q3;
  logic [1:0]               rem3;
  logic [MONTH_W-1:0]       rem12;
  logic signed [MW-1:0]     dy;
  logic signed [SW-1:0]     dy_ext;
  logic [MONTH_W-1:0]       mon_r;

  assign leap_op = (state == ST_LD1) ? ld_year : year_reg;

  cds_leap u_leap (
    .clk  (clk),
    .year (leap_op),
    .leap (leap_q)
  );

  // amount decode and month offset
  assign amt_u   = cmd.amount;
  assign amt_ext = SW'(cmd.amount);
  assign m0      = $signed({{(MW-MONTH_W){1'b0}}, month_reg}) - MW'(1)
                   + MW'(cmd.amount);

  // per-state arithmetic
  assign cur_md = month_days(month_reg, leap_reg);
  assign gap    = cur_md - day_reg;
  assign ld_ok  = !ld_year[YEAR_W-1] && (ld_month >= MON_JAN) && (ld_month <= MONTHS)
                  && (ld_day != '0) && (ld_day <= month_days(ld_month, leap_q));

  // quotient of the magnitude by 12
  assign div_y    = div_q[MW-1:2];
  assign div_prod = PW'(div_y) * PW'(RECIP3);
  assign div_q3   = div_prod[PW-1:RK];

  // remainder from the low bits: y - 3q is y + q modulo 4
  assign rem3   = div_rem[3:2] + div_q[1:0];
  assign rem12  = {rem3, div_rem[1:0]};
  assign dy     = div_neg ? $signed(~div_q) : $signed(div_q);
  assign dy_ext = SW'(dy);
  assign mon_r  = div_neg ? (MONTHS - MONTH_W'(1) - rem12) : rem12;

  // handshake
  assign cmd.ready = (state == ST_IDLE);

  assign res.valid      = out_valid;
  assign res.cur_day    = out_day;
  assign res.cur_month  = out_month;
  assign res.cur_year   = out_year;
  assign res.date_valid = out_dvalid;
  assign res.load_error = out_err;
  assign res.month_days = out_mdays;
  assign res.leap_year  = out_leap;

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_FIN;
      day_reg   <= RESET_DAY;
      month_reg <= RESET_MONTH;
      year_reg  <= RESET_YEAR;
      leap_reg  <= 1'b0;
      err_reg   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      day_reg   <= day_next;
      month_reg <= month_next;
      year_reg  <= year_next;
      leap_reg  <= leap_next;
      err_reg   <= err_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_day     <= ld_day_next;
    ld_month   <= ld_month_next;
    ld_year    <= ld_year_next;
    day_rem    <= day_rem_next;
    div_q      <= div_q_next;
    div_rem    <= div_rem_next;
    div_neg    <= div_neg_next;
    out_day    <= out_day_next;
    out_month  <= out_month_next;
    out_year   <= out_year_next;
    out_dvalid <= out_dvalid_next;
    out_err    <= out_err_next;
    out_mdays  <= out_mdays_next;
    out_leap   <= out_leap_next;
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_next      = state;
    ret_state_next  = ret_state;
    day_next        = day_reg;
    month_next      = month_reg;
    year_next       = year_reg;
    leap_next       = leap_reg;
    err_next        = err_reg;
    ld_day_next     = ld_day;
    ld_month_next   = ld_month;
    ld_year_next    = ld_year;
    day_rem_next    = day_rem;
    div_q_next      = div_q;
    div_rem_next    = div_rem;
    div_neg_next    = div_neg;
    out_valid_next  = out_valid && !res.ready;
    out_day_next    = out_day;
    out_month_next  = out_month;
    out_year_next   = out_year;
    out_dvalid_next = out_dvalid;
    out_err_next    = out_err;
    out_mdays_next  = out_mdays;
    out_leap_next   = out_leap;

    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          err_next = 1'b0;
          case (func_t'(cmd.func))
            FN_LOAD: begin
              ld_day_next   = cmd.load_day;
              ld_month_next = cmd.load_month;
              ld_year_next  = cmd.load_year;
              state_next    = ST_LD1;
            end
            FN_DAYS: begin
              day_rem_next = amt_u[AMOUNT_BITS-1] ? (~amt_u + 1'b1) : amt_u;
              if (amt_u == '0) begin
                state_next = ST_FIN;
              end else if (amt_u[AMOUNT_BITS-1]) begin
                state_next = ST_DAYB;
              end else begin
                state_next = ST_DAYF;
              end
            end
            FN_MONTHS: begin
              // floor divide by 12 done on the magnitude side of the sign
              div_neg_next = m0[MW-1];
              div_q_next   = m0[MW-1] ? ~m0 : m0;
              div_rem_next = '0;
              state_next   = ST_DIV;
            end
            FN_YEARS: begin
              year_next      = year_reg + amt_ext[YEAR_W-1:0];
              ret_state_next = ST_YFIX;
              state_next     = ST_LEAP1;
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end

      // leap unit samples the load year
      ST_LD1: begin
        state_next = ST_LD2;
      end

      ST_LD2: begin
        if (ld_ok) begin
          day_next   = ld_day;
          month_next = ld_month;
          year_next  = ld_year;
          leap_next  = leap_q;
        end else begin
          err_next = 1'b1;
        end
        state_next = ST_FIN;
      end

      // divide by 12: keep the low bits, replace the magnitude by the quotient
      ST_DIV: begin
        div_q_next   = MW'(div_q3);
        div_rem_next = div_q[3:0];
        state_next   = ST_MEND;
      end

      ST_MEND: begin
        month_next     = mon_r + MONTH_W'(1);
        year_next      = year_reg + dy_ext[YEAR_W-1:0];
        ret_state_next = ST_FIN;
        state_next     = ST_LEAP1;
      end

      // rerun the leap unit on the current year
      ST_LEAP1: begin
        state_next = ST_LEAP2;
      end

      ST_LEAP2: begin
        leap_next  = leap_q;
        state_next = ret_state;
      end

      // a February day past the month end becomes 1 March
      ST_YFIX: begin
        if ((month_reg == MON_FEB) && (day_reg > cur_md)) begin
          day_next   = RESET_DAY;
          month_next = MON_MAR;
        end
        state_next = ST_FIN;
      end

      // forward days, one month a cycle, pausing for the leap rerun on each new year
      ST_DAYF: begin
        if (day_rem == '0) begin
          state_next = ST_FIN;
        end else if ((day_reg < cur_md) && (CW'(day_rem) <= CW'(gap))) begin
          day_next     = day_reg + DAY_W'(day_rem);
          day_rem_next = '0;
          state_next   = ST_FIN;
        end else begin
          if (day_reg >= cur_md) begin
            day_rem_next = day_rem - 1'b1;
          end else begin
            day_rem_next = day_rem - AMOUNT_BITS'({1'b0, gap} + 6'd1);
          end
          day_next = RESET_DAY;
          if (month_reg == MONTHS) begin
            month_next     = MON_JAN;
            year_next      = year_reg + 1'b1;
            ret_state_next = ST_DAYF;
            state_next     = ST_LEAP1;
          end else begin
            month_next = month_reg + 1'b1;
          end
        end
      end

      // backward days, one month a cycle, pausing for the leap rerun on each new year
      ST_DAYB: begin
        if (day_rem == '0) begin
          state_next = ST_FIN;
        end else if (CW'(day_reg) > CW'(day_rem)) begin
          day_next     = day_reg - DAY_W'(day_rem);
          day_rem_next = '0;
          state_next   = ST_FIN;
        end else begin
          day_rem_next = day_rem - AMOUNT_BITS'(day_reg);
          if (month_reg == MON_JAN) begin
            month_next     = MONTHS;
            year_next      = year_reg - 1'b1;
            day_next       = DAYS_LONG;
            ret_state_next = ST_DAYB;
            state_next     = ST_LEAP1;
          end else begin
            month_next = month_reg - 1'b1;
            day_next   = month_days(month_reg - 1'b1, leap_reg);
          end
        end
      end

      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!out_valid || res.ready) begin
          out_valid_next  = 1'b1;
          out_day_next    = day_reg;
          out_month_next  = month_reg;
          out_year_next   = year_reg;
          out_dvalid_next = !year_reg[YEAR_W-1] && (day_reg != '0)
                            && (day_reg <= cur_md);
          out_err_next    = err_reg;
          out_mdays_next  = cur_md;
          out_leap_next   = leap_reg;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.cur_month >= MON_JAN && res.cur_month <= MONTHS))
    else $error("result month out of range");

  a_reject_keeps_date: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LD2 && !ld_ok) |=>
      (day_reg == $past(day_reg) && month_reg == $past(month_reg) &&
       year_reg == $past(year_reg) && err_reg))
    else $error("rejected load changed the date");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_MEND |-> rem12 < MONTHS)
    else $error("divider remainder not below 12");

  a_leap_return: assert property (@(posedge clk) disable iff (rst)
    state == ST_LEAP2 |-> (ret_state == ST_FIN || ret_state == ST_YFIX ||
                           ret_state == ST_DAYF || ret_state == ST_DAYB))
    else $error("leap rerun returns to an unexpected state");

  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> day_reg != '0)
    else $error("stored day is zero");

endmodule
